### hdl/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants for the text line folder
// character codes and the control bundle that drives the row of store cells
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int unsigned CHAR_W = 8;
  // fill count and positions, wide enough for a line of up to 63 characters
  localparam int unsigned POS_W  = 6;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

  typedef struct packed {
    logic              shift;    // every cell takes its right neighbour
    logic              wr_char;  // the cell at pos takes wchar
    logic              wr_tab;   // cells in [pos, stop) take a blank
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  stop;
    logic [CHAR_W-1:0] wchar;
  } cell_ctrl_t;

endpackage

### hdl/tlf_cell.sv
// ----------------------------------------------------------------------------
// tlf_cell: one character cell of the line store
// holds one character, shifts left towards the output or takes a write
// ----------------------------------------------------------------------------
module tlf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  tlf_pkg::cell_ctrl_t          ctrl_i,
  input  logic [tlf_pkg::CHAR_W-1:0]   right_i,
  output logic [tlf_pkg::CHAR_W-1:0]   data_o
);

  localparam logic [tlf_pkg::POS_W-1:0] MY_IDX = tlf_pkg::POS_W'(IDX);

  logic [tlf_pkg::CHAR_W-1:0] data_q;
  logic                       hit_char;
  logic                       hit_tab;

  assign hit_char = ctrl_i.wr_char && (ctrl_i.pos == MY_IDX);
  assign hit_tab  = ctrl_i.wr_tab && (MY_IDX >= ctrl_i.pos) && (MY_IDX < ctrl_i.stop);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= right_i;
    end else if (hit_char) begin
      data_q <= ctrl_i.wchar;
    end else if (hit_tab) begin
      data_q <= tlf_pkg::CH_BLANK;
    end
  end

  assign data_o = data_q;

endmodule

### hdl/text_line_folder.sv
// ----------------------------------------------------------------------------
// text_line_folder: folds long text lines at the last blank
// one character per input beat, folded text with newlines on the output
// ----------------------------------------------------------------------------
// The line is held in a row of LINE_WIDTH character cells with a fill count.
// Characters are written into the cell at the fill position; a tab writes
// blanks up to the next TAB_WIDTH stop in a single write. When the line fills,
// it is folded after the last blank at index one or higher (or cut whole
// if there is none), a newline ends each printed line, and a newline input
// flushes the line (an empty line prints nothing). Output characters are
// taken from cell zero while the whole row shifts left by one per character printed,
// so after a fold the leftover text already sits at the front. The last
// blank is tracked as characters arrive, so no search is needed at a fold.
// Timing: a beat that prints nothing is followed by the next one in the next
// cycle; a beat that prints characters (including the newline) holds off
// the input until its closing newline is loaded, each stored character taken
// with one step of the cell row shift, and longer while the output stalls. The last
// newline may still wait in the output register while the next input beat
// is taken. Text left in the store at end of input is never printed.
// ----------------------------------------------------------------------------
module text_line_folder #(
  parameter int unsigned LINE_WIDTH = 32,  // 2 .. 63
  parameter int unsigned TAB_WIDTH  = 8    // 1 .. 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // last_of_run
);

  localparam int unsigned PW = tlf_pkg::POS_W;
  localparam int unsigned CW = tlf_pkg::CHAR_W;
  localparam int unsigned IW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

  localparam logic [PW-1:0] LW_P     = PW'(LINE_WIDTH);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_WIDTH - 1);
  localparam logic [PW-1:0] ONE_P    = PW'(1);

  typedef logic [LINE_WIDTH-1:0][PW-1:0] stop_tbl_t;

  // next tab stop for each fill position, clipped to the line width
  function automatic stop_tbl_t build_stops();
    stop_tbl_t t;
    int unsigned s;
    for (int unsigned i = 0; i < LINE_WIDTH; i++) begin
      s = ((i / TAB_WIDTH) + 1) * TAB_WIDTH;
      if (s > LINE_WIDTH) begin
        s = LINE_WIDTH;
      end
      t[i] = PW'(s);
    end
    return t;
  endfunction

  localparam stop_tbl_t TAB_STOP = build_stops();

  // control state
  logic [PW-1:0] cnt_q, cnt_d;     // fill count
  logic          lbv_q, lbv_d;     // a blank at index one or higher is stored
  logic [PW-1:0] lb_q, lb_d;       // index of that last blank
  logic [PW-1:0] rem_q, rem_d;     // stored characters still to print
  logic          nl_q, nl_d;       // newline still to print
  logic          ov_q, ov_d;       // output register holds a beat
  logic [CW-1:0] od_q, od_d;
  logic          ol_q, ol_d;

  logic          busy;
  logic          accept;
  logic          load;
  logic          is_tab;
  logic          is_nl;
  logic          blank_here;
  logic [PW-1:0] stop;
  logic [PW-1:0] cut;

  tlf_pkg::cell_ctrl_t        ctrl;
  logic [LINE_WIDTH-1:0][CW-1:0] cell_data;

  assign busy          = (rem_q != '0) || nl_q;
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign load          = busy && (!ov_q || m_axis_tready);

  assign is_tab     = (s_axis_tdata == tlf_pkg::CH_TAB);
  assign is_nl      = (s_axis_tdata == tlf_pkg::CH_NL);
  assign blank_here = (s_axis_tdata == tlf_pkg::CH_BLANK) && (cnt_q != '0);
  assign stop       = TAB_STOP[cnt_q[IW-1:0]];

  // fold point: just past the last blank, or the whole line
  always_comb begin
    if (blank_here) begin
      cut = LW_P;
    end else if (lbv_q) begin
      cut = lb_q + ONE_P;
    end else begin
      cut = LW_P;
    end
  end

  // row of cells
  always_comb begin
    ctrl.shift   = load && (rem_q != '0);
    ctrl.wr_char = accept && !is_tab && !is_nl;
    ctrl.wr_tab  = accept && is_tab;
    ctrl.pos     = cnt_q;
    ctrl.stop    = stop;
    ctrl.wchar   = s_axis_tdata;
  end

  for (genvar i = 0; i < LINE_WIDTH; i++) begin : g_cell
    logic [CW-1:0] right;
    if (i == LINE_WIDTH - 1) begin : g_end
      assign right = tlf_pkg::CH_BLANK;
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    tlf_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // accept and print control
  always_comb begin
    cnt_d = cnt_q;
    lbv_d = lbv_q;
    lb_d  = lb_q;
    rem_d = rem_q;
    nl_d  = nl_q;
    ov_d  = ov_q;
    od_d  = od_q;
    ol_d  = ol_q;

    if (accept) begin
      if (is_tab) begin
        if (stop == LW_P) begin
          // tab reaches the end of the line: print it whole
          rem_d = LW_P;
          nl_d  = 1'b1;
          cnt_d = '0;
          lbv_d = 1'b0;
        end else begin
          cnt_d = stop;
          if (stop > ONE_P) begin
            lbv_d = 1'b1;
            lb_d  = stop - ONE_P;
          end
        end
      end else if (is_nl) begin
        rem_d = cnt_q;
        nl_d  = (cnt_q != '0);
        cnt_d = '0;
        lbv_d = 1'b0;
      end else if (cnt_q == LAST_POS) begin
        // line full: fold, leftover has no blank
        rem_d = cut;
        nl_d  = 1'b1;
        cnt_d = LW_P - cut;
        lbv_d = 1'b0;
      end else begin
        cnt_d = cnt_q + ONE_P;
        if (blank_here) begin
          lbv_d = 1'b1;
          lb_d  = cnt_q;
        end
      end
    end

    if (load) begin
      ov_d = 1'b1;
      if (rem_q != '0) begin
        od_d  = cell_data[0];
        ol_d  = 1'b0;
        rem_d = rem_q - ONE_P;
      end else begin
        od_d = tlf_pkg::CH_NL;
        ol_d = 1'b1;
        nl_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lbv_q <= 1'b0;
      rem_q <= '0;
      nl_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      lbv_q <= lbv_d;
      rem_q <= rem_d;
      nl_q  <= nl_d;
      ov_q  <= ov_d;
    end
  end

  // output payload and blank index need no reset
  always_ff @(posedge clk_i) begin
    lb_q <= lb_d;
    od_q <= od_d;
    ol_q <= ol_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

`ifndef SYNTHESIS
  // fill count never reaches the line width
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < LW_P)
    else $error("fill count out of range");

  // a tracked blank lies inside the stored text, past index zero
  a_blank_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbv_q |-> (lb_q < cnt_q) && (lb_q != '0))
    else $error("last blank index outside stored text");

  // printed characters are always followed by a newline
  a_nl_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> nl_q)
    else $error("line printed without a closing newline");

  // once the closing newline is loaded the input opens again
  a_reopen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (rem_q == '0)) |=> s_axis_tready)
    else $error("input still held after closing newline");
`endif

endmodule

### verif/text_line_folder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_line_folder_tb: self-checking bench for the text line folder
// feeds character beats with random gaps and output stalls, folds the same
// text in a behavioural model and compares every printed beat in order
// ----------------------------------------------------------------------------
module text_line_folder_tb;

  localparam int unsigned LINE_WIDTH = 32;
  localparam int unsigned TAB_WIDTH  = 8;
  // cycles to keep watching the output once nothing is awaited
  localparam int unsigned DRAIN_CYCLES = 40;
  // long output hold-off that lets the folder fill up and stall its input
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned RANDOM_CHARS = 80;

  // one printed beat: character and end-of-run flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } print_beat_t;

  // one row of the directed script; a negative beat count means the
  // expected text comes from the folding model, otherwise it is typed in
  // as that many beats of fill_ch, the final beat a newline instead
  typedef struct packed {
    logic [7:0] ch;
    int         want_n;
    logic [7:0] fill_ch;
  } script_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // folding model state
  logic [7:0]  line_buf [LINE_WIDTH];
  int unsigned line_fill = 0;

  print_beat_t printed_q [$];  // beats that one character prints
  print_beat_t awaited_q [$];  // printed beats still to arrive, oldest first

  int unsigned chars_in  = 0;  // character beats taken by the folder
  int unsigned errors    = 0;
  bit          src_calm  = 1'b0;
  bit          sink_calm = 1'b0;

  script_row_t script [25] = '{
    '{tlf_pkg::CH_NL,    0,  8'h00},             // empty line straight after reset
    '{8'h00,             0,  8'h00},             // lowest byte stored
    '{8'hFF,             0,  8'h00},             // highest byte stored
    '{tlf_pkg::CH_NL,    -1, 8'h00},             // prints both bytes and a newline
    '{tlf_pkg::CH_NL,    0,  8'h00},             // empty line again
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_TAB,   33, tlf_pkg::CH_BLANK}, // tab reaching the end
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_NL,    9,  tlf_pkg::CH_BLANK}, // one tab stop of blanks
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{tlf_pkg::CH_TAB,   0,  8'h00},
    '{8'h61,             0,  8'h00},
    '{8'h62,             0,  8'h00},
    '{8'h63,             0,  8'h00},
    '{8'h64,             0,  8'h00},
    '{8'h65,             0,  8'h00},
    '{8'h66,             0,  8'h00},
    '{8'h67,             0,  8'h00},
    '{tlf_pkg::CH_BLANK, -1, 8'h00},             // blank in the last cell
    '{8'h68,             -1, 8'h00},
    '{tlf_pkg::CH_TAB,   -1, 8'h00},             // tab from an odd position
    '{tlf_pkg::CH_NL,    -1, 8'h00}
  };

  text_line_folder #(
    .LINE_WIDTH (LINE_WIDTH),
    .TAB_WIDTH  (TAB_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char
    .m_axis_tlast  (m_axis_tlast)    // last_of_run
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---- folding model --------------------------------------------------------

  // the first n stored characters, then a newline unless n is zero
  function automatic void print_head(int unsigned n);
    for (int unsigned i = 0; i < n && i < LINE_WIDTH; i++) begin
      printed_q.push_back(print_beat_t'{line_buf[i], 1'b0});
    end
    if (n > 0) begin
      printed_q.push_back(print_beat_t'{tlf_pkg::CH_NL, 1'b0});
    end
  endfunction

  // takes one character into the line, leaves what it prints in printed_q
  function automatic void fold_char(logic [7:0] c);
    int unsigned p;
    int unsigned i;
    int unsigned cut;
    int unsigned n;
    printed_q.delete();
    p = line_fill;
    if (c == tlf_pkg::CH_TAB) begin
      line_buf[p] = tlf_pkg::CH_BLANK;
      p++;
      while (p < LINE_WIDTH && (p % TAB_WIDTH) != 0) begin
        line_buf[p] = tlf_pkg::CH_BLANK;
        p++;
      end
      // the tab ran to the end of the line: print all of it
      if (p >= LINE_WIDTH) begin
        print_head(LINE_WIDTH);
        p = 0;
      end
    end else if (c == tlf_pkg::CH_NL) begin
      // flush; an empty line prints nothing
      print_head(p);
      p = 0;
    end else begin
      line_buf[p] = c;
      p++;
      if (p >= LINE_WIDTH) begin
        // look for the last blank from the last cell down to cell one
        i = LINE_WIDTH - 1;
        while (i > 0 && line_buf[i] != tlf_pkg::CH_BLANK) begin
          i--;
        end
        cut = (i == 0) ? LINE_WIDTH : i + 1;
        print_head(cut);
        // move the unprinted tail to the front
        n = 0;
        for (int unsigned j = cut; j < LINE_WIDTH; j++) begin
          line_buf[n] = line_buf[j];
          n++;
        end
        p = n;
      end
    end
    line_fill = p;
    if (printed_q.size() > 0) begin
      printed_q[printed_q.size() - 1].last = 1'b1;
    end
  endfunction

  // ---- input side -----------------------------------------------------------

  // offers one character beat after a random gap and books what it prints
  task automatic send_char(logic [7:0] c, int want_n = -1, logic [7:0] fill_ch = 8'h00);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) begin
      src_calm = !src_calm;
    end
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_in++;
    fold_char(c);
    if (want_n < 0) begin
      foreach (printed_q[k]) awaited_q.push_back(printed_q[k]);
    end else begin
      // typed expectation: a run of one character closed by a newline
      for (int k = 0; k < want_n - 1; k++) begin
        awaited_q.push_back(print_beat_t'{fill_ch, 1'b0});
      end
      if (want_n > 0) begin
        awaited_q.push_back(print_beat_t'{tlf_pkg::CH_NL, 1'b1});
      end
    end
  endtask

  // a character that is neither tab, newline nor blank; mostly printable
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c == tlf_pkg::CH_TAB || c == tlf_pkg::CH_NL || c == tlf_pkg::CH_BLANK);
    end else begin
      c = 8'($urandom_range(33, 126));
    end
    return c;
  endfunction

  task automatic send_word(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_char(text_char());
    end
  endtask

  // ---- output side ----------------------------------------------------------

  task automatic check_beat(logic [7:0] ch, logic last);
    print_beat_t w;
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual out_char=%02h last=%0b",
               $time, ch, last);
      errors++;
    end else begin
      w = awaited_q.pop_front();
      if (w.ch !== ch) begin
        $display("%0t: out_char mismatch, expected %02h, actual %02h", $time, w.ch, ch);
        errors++;
      end
      if (w.last !== last) begin
        $display("%0t: tlast mismatch, expected %0b, actual %0b", $time, w.last, last);
        errors++;
      end
    end
  endtask

  // receiver: random stall before each beat, one long hold-off mid-run
  initial begin : drain
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        sink_calm = !sink_calm;
      end
      stall = sink_calm ? 0 : $urandom_range(0, 11);
      if (!held && chars_in >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_beat(m_axis_tdata, m_axis_tlast);
    end
  end

  // ---- stimulus -------------------------------------------------------------

  initial begin : stimulus
    int unsigned start;
    int unsigned kind;
    int unsigned pick;
    bit          first;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    foreach (script[r]) begin
      send_char(script[r].ch, script[r].want_n, script[r].fill_ch);
    end

    // random text: mostly words and separators, some long unbroken words
    // that can force a fold with no blank, empty lines and raw byte noise
    start = chars_in;
    first = 1'b1;
    while (chars_in - start < RANDOM_CHARS) begin
      kind  = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      if (kind == 0) begin
        send_word($urandom_range(LINE_WIDTH - 1, LINE_WIDTH + 13));
      end else if (kind <= 6) begin
        send_word($urandom_range(1, 9));
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_char(tlf_pkg::CH_BLANK);
        end else if (pick < 8) begin
          send_char(tlf_pkg::CH_TAB);
        end else begin
          send_char(tlf_pkg::CH_NL);
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 3)) send_char(tlf_pkg::CH_NL);
      end else begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // wait for every booked beat, then watch for strays
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
